// File: rtl/pnc_pkg.sv
package pnc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
	localparam int COMP_W          = 6;
	localparam int SQ_W            = 2 * COMP_W;
	localparam int DIST_W          = 25;
	localparam int S_DATA_W        = 32;
	localparam int M_DATA_W        = 8;
	localparam int OUT_IDX_W       = 8;

	localparam logic [DIST_W-1:0] W_RED   = DIST_W'(30 * 30);
	localparam logic [DIST_W-1:0] W_GREEN = DIST_W'(59 * 59);
	localparam logic [DIST_W-1:0] W_BLUE  = DIST_W'(11 * 11);

	localparam logic [COMP_W-1:0] MASK_RED   = COMP_W'(63);
	localparam logic [COMP_W-1:0] MASK_GREEN = COMP_W'(0);
	localparam logic [COMP_W-1:0] MASK_BLUE  = COMP_W'(63);

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

// File: rtl/pnc_ram.sv
module pnc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pnc_dist.sv
module pnc_dist
	import pnc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tag_t              tag_in,
	input  rgb_t              entry,
	input  rgb_t              query,
	output tag_t              tag_out,
	output logic [DIST_W-1:0] distance,
	output logic              busy
);

	tag_t              tag_s2, tag_s3, tag_s4;
	logic [COMP_W-1:0] dr, dg, db;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] w_r_s3, w_g_s3, w_b_s3;
	logic [DIST_W-1:0] dist_s4;

	always_comb begin
		dr = (entry.red   >= query.red)   ? entry.red   - query.red   : query.red   - entry.red;
		dg = (entry.green >= query.green) ? entry.green - query.green : query.green - entry.green;
		db = (entry.blue  >= query.blue)  ? entry.blue  - query.blue  : query.blue  - entry.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
		w_r_s3  <= DIST_W'(sq_r_s2) * W_RED;
		w_g_s3  <= DIST_W'(sq_g_s2) * W_GREEN;
		w_b_s3  <= DIST_W'(sq_b_s2) * W_BLUE;
		dist_s4 <= w_r_s3 + w_g_s3 + w_b_s3;
	end

	assign tag_out  = tag_s4;
	assign distance = dist_s4;
	assign busy     = tag_s2.valid | tag_s3.valid | tag_s4.valid;

endmodule

// File: rtl/palette_nearest_color_search_top.sv
// Load word: accepted while idle, ready stays high.
// Query word: one palette read per cycle over slots 1..N-1 (0..N-1 for the mask color),
// then the RAM read stage and the distance pipe (s2, s3, s4) drain before the result is registered.
// A new query is taken only after the previous search has finished, as the single RAM read port scans the palette.
// arst_n clears the sequencer and output valid; palette contents stay undefined until loaded.
module palette_nearest_color_search_top
	import pnc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // entry_index[7:0], red[13:8], green[19:14], blue[25:20]
	input  logic                s_tuser,  // kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // best_index[7:0]
);

	state_t            state_q, state_d;
	rgb_t              in_rgb, query_q, rd_data;
	logic [7:0]        in_index;
	logic              s_acc, is_mask, load_we, issue, last, pipe_busy, finish;
	logic [IDX_W-1:0]  cnt_q;
	tag_t              tag_s1, tag_res;
	logic [DIST_W-1:0] dist_res, lowest_q;
	logic [IDX_W-1:0]  best_q;
	logic              have_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	assign in_index     = s_tdata[7:0];
	assign in_rgb.red   = s_tdata[13:8];
	assign in_rgb.green = s_tdata[19:14];
	assign in_rgb.blue  = s_tdata[25:20];

	assign s_acc   = s_tvalid & s_tready;
	assign is_mask = (in_rgb.red == MASK_RED) && (in_rgb.green == MASK_GREEN)
		&& (in_rgb.blue == MASK_BLUE);
	assign load_we = s_acc && (s_tuser == KIND_LOAD)
		&& (32'(in_index) < 32'(PALETTE_ENTRIES));
	assign last    = (cnt_q == IDX_W'(PALETTE_ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && (s_tuser == KIND_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_SCAN:  issue    = 1'b1;
			ST_DRAIN: finish   = !tag_s1.valid && !pipe_busy && (!m_tvalid_q || m_tready);
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tag_s1     <= '0;
			have_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			tag_s1.valid <= issue;
			tag_s1.idx   <= cnt_q;
			if (s_acc && (s_tuser == KIND_QUERY)) begin
				have_q <= 1'b0;
			end else if (tag_res.valid && (!have_q || dist_res < lowest_q)) begin
				have_q <= 1'b1;
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && (s_tuser == KIND_QUERY)) begin
			query_q <= in_rgb;
			cnt_q   <= IDX_W'(!is_mask);
		end else if (issue) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
		if (tag_res.valid && (!have_q || dist_res < lowest_q)) begin
			lowest_q <= dist_res;
			best_q   <= tag_res.idx;
		end
		if (finish) begin
			m_tdata_q <= M_DATA_W'(OUT_IDX_W'(best_q));
		end
	end

	pnc_ram #(
		.WIDTH($bits(rgb_t)),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(IDX_W'(in_index)),
		.wdata(in_rgb),
		.raddr(cnt_q),
		.rdata(rd_data)
	);

	pnc_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s1),
		.entry   (rd_data),
		.query   (query_q),
		.tag_out (tag_res),
		.distance(dist_res),
		.busy    (pipe_busy)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: rtl/pnc_chk.sv
module pnc_chk
	import pnc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_QUERY) |=> !s_tready)
		else $error("ready after query accept");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> s_tready)
		else $error("ready dropped after load");

	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready && $past(!s_tready))
		else $error("result outside end of search");

endmodule

bind palette_nearest_color_search_top pnc_chk u_pnc_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
